/* design/circular_deque_unit_defines.svh */
// Assertion macros used by the circular deque datapath.
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset.
`define DQ_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define DQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

/* design/dq_pkg.sv */
// Package with types and constants for the circular deque unit.
`timescale 1ns / 1ps
package dq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int OPCODE_W  = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_LIST       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } dq_state_t;

  typedef struct packed {
    logic                single;
    logic [OPCODE_W-1:0] op;
    logic                list_init;
    logic                rd_en;
    logic                emit;
  } dq_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic out_busy;
    logic list_last;
  } dq_sts_t;

endpackage

/* design/dq_ctrl.sv */
// Controller state machine for the circular deque unit.
`timescale 1ns / 1ps
module dq_ctrl
  import dq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [OPCODE_W-1:0] in_opcode,
  output logic                in_stall,
  input  dq_sts_t             sts,
  output dq_cmd_t             cmd
);

  dq_state_t state_r, state_nxt;
  logic      accept;

  assign in_stall = (state_r != S_IDLE) || sts.out_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd.single    = 1'b0;
    cmd.op        = in_opcode;
    cmd.list_init = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.emit      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT, OP_POP_BACK: begin
              cmd.single = 1'b1;
            end
            OP_LIST: begin
              if (sts.count_zero) begin
                cmd.single = 1'b1;
              end else begin
                cmd.list_init = 1'b1;
                state_nxt     = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.list_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/dq_datapath.sv */
// Datapath of the circular deque unit: ring memory, pointers and output register.
`timescale 1ns / 1ps
`include "circular_deque_unit_defines.svh"
module dq_datapath
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dq_cmd_t                    cmd,
  output dq_sts_t                    sts,
  input  logic signed [VALUE_W-1:0]  in_item_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [VALUE_W-1:0]  out_value,
  output logic                       out_last_of_run
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [VALUE_W-1:0]  mem [DEPTH];
  logic [VALUE_W-1:0]  rdata_r;

  logic [IDX_W-1:0]    front_r, front_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    lptr_r, lptr_nxt;
  logic [CNT_W-1:0]    lidx_r, lidx_nxt;

  logic                ov_r, ov_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic                last_r, last_nxt;

  logic                full, empty;
  logic [IDX_W-1:0]    front_dec, front_inc, lptr_inc, tail_idx;
  logic [SUM_W-1:0]    tail_sum;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic                load;
  logic                push_ok;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - IDX_W'(1);
  assign front_inc = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + IDX_W'(1);
  assign lptr_inc  = (lptr_r == IDX_W'(DEPTH - 1)) ? '0 : lptr_r + IDX_W'(1);
  assign tail_sum  = SUM_W'(front_r) + SUM_W'(count_r);
  assign tail_idx  = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                : IDX_W'(tail_sum);

  assign push_ok = cmd.single && !full && (cmd.op == OP_PUSH_FRONT || cmd.op == OP_PUSH_BACK);

  assign sts.count_zero = empty;
  assign sts.out_busy   = ov_r && out_stall;
  assign sts.list_last  = (SUM_W'(lidx_r) + SUM_W'(1)) == SUM_W'(count_r);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    lptr_nxt  = lptr_r;
    lidx_nxt  = lidx_r;
    wr_en     = 1'b0;
    wr_addr   = tail_idx;
    load      = 1'b0;
    st_nxt    = st_r;
    val_nxt   = val_r;
    last_nxt  = last_r;
    if (cmd.single) begin
      load     = 1'b1;
      st_nxt   = ST_OK;
      val_nxt  = '0;
      last_nxt = 1'b1;
      unique case (cmd.op)
        OP_PUSH_FRONT: begin
          if (full) begin
            st_nxt = ST_FULL;
          end else begin
            front_nxt = front_dec;
            wr_en     = 1'b1;
            wr_addr   = front_dec;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            st_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = tail_idx;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            st_nxt = ST_EMPTY;
          end else begin
            front_nxt = front_inc;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            st_nxt = ST_EMPTY;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        OP_LIST: begin
          st_nxt = ST_EMPTY;
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
    if (cmd.list_init) begin
      lptr_nxt = front_r;
      lidx_nxt = '0;
    end
    if (cmd.emit) begin
      load     = 1'b1;
      st_nxt   = ST_OK;
      val_nxt  = rdata_r;
      last_nxt = sts.list_last;
      lptr_nxt = lptr_inc;
      lidx_nxt = lidx_r + CNT_W'(1);
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_item_value;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[lptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lptr_r <= lptr_nxt;
    lidx_r <= lidx_nxt;
    st_r   <= st_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = st_r;
  assign out_value       = val_r;
  assign out_last_of_run = last_r;

  `DQ_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `DQ_ASSERT_IMPL(a_no_load_busy, clk, rst_n, cmd.single || cmd.emit, !(ov_r && out_stall))
  `DQ_ASSERT_NEXT(a_push_grows, clk, rst_n, push_ok, count_r == $past(count_r) + CNT_W'(1))

endmodule

/* design/circular_deque_unit.sv */
// Push/pop: output register loaded at the accepting edge; one per cycle unless output stalls.
// List: each stored item takes a ring read (S_READ), then an output register load
// (S_EMIT) that waits while the output stalls; an empty list gives one status at once.
// Input stalls while a list runs and while a waiting result in the output register stalls.
// Synchronous active-low reset clears front index, item count, controller and output valid;
// ring contents stay undefined until written, no clearing pass.
`timescale 1ns / 1ps
module circular_deque_unit
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OPCODE_W-1:0]       in_opcode,
  input  logic signed [VALUE_W-1:0] in_item_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STATUS_W-1:0]       out_status,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_last_of_run
);

  dq_cmd_t cmd;
  dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run)
  );

endmodule
